@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define NFSA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nfsa assertion failed");

// antecedent implies consequent in the next cycle
`define NFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nfsa assertion failed");

`endif

@@ src/nfsa_pkg.sv @@
// ----------------------------------------------------------------------------
// nfsa_pkg
// Types, constants and helpers of the next-fit slot allocator.
// ----------------------------------------------------------------------------
package nfsa_pkg;

    localparam int SLOTS     = 1024;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int NUM_WORDS = SLOTS / WORD_W;
    localparam int WADDR_W   = $clog2(NUM_WORDS);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [WADDR_W-1:0] t_waddr;
    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [CNT_W-1:0]   t_cnt;

    typedef struct packed {
        logic   rd_en;
        t_waddr rd_addr;
        logic   wr_en;
        t_waddr wr_addr;
        t_word  wr_data;
    } t_mem_req;

    typedef struct packed {
        t_status status;
        t_slot   granted_slot;
        t_cnt    used_count;
    } t_result;

    function automatic logic [BIT_W-1:0] lowest_set(input t_word w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ src/nfsa_ifs.sv @@
// ----------------------------------------------------------------------------
// nfsa_ifs
// Handshake channels of the allocator: config write, request, response.
// ----------------------------------------------------------------------------
interface nfsa_cfg_if import nfsa_pkg::*;;
    logic valid;
    logic ready;
    t_cnt pool_size;

    modport source (output valid, output pool_size, input ready);
    modport sink   (input valid, input pool_size, output ready);
endinterface

interface nfsa_req_if import nfsa_pkg::*;;
    logic  valid;
    logic  ready;
    logic  mode;
    t_slot slot;

    modport source (output valid, output mode, output slot, input ready);
    modport sink   (input valid, input mode, input slot, output ready);
endinterface

interface nfsa_rsp_if import nfsa_pkg::*;;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    t_slot       granted_slot;
    t_cnt        used_count;

    modport source (output valid, output status, output granted_slot,
                    output used_count, input ready);
    modport sink   (input valid, input status, input granted_slot,
                    input used_count, output ready);
endinterface

@@ src/nfsa_bitmap.sv @@
// ----------------------------------------------------------------------------
// nfsa_bitmap
// Used-bit memory, one 32-bit word per row, registered read, row valid bits.
// ----------------------------------------------------------------------------
module nfsa_bitmap import nfsa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_mem,
    output t_word    o_rd_data
);

    t_word                r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_row_vld;
    t_word                r_rd_raw;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_mem.wr_en) begin
            r_mem[i_mem.wr_addr] <= i_mem.wr_data;
        end
        if (i_mem.rd_en) begin
            r_rd_raw <= r_mem[i_mem.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_mem.wr_en) begin
                r_row_vld[i_mem.wr_addr] <= 1'b1;
            end
            if (i_mem.rd_en) begin
                r_rd_vld <= r_row_vld[i_mem.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_raw : '0;

endmodule

@@ src/nfsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// nfsa_ctrl
// Request sequencer: word scan over the bitmap, read-modify-write, counters.
// ----------------------------------------------------------------------------
module nfsa_ctrl import nfsa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cnt     i_size,
    nfsa_req_if.sink i_req,
    output t_mem_req o_mem,
    input  t_word    i_rd_data,
    output logic     o_res_valid,
    output t_result  o_res,
    input  logic     i_res_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE_RD,
        S_FREE_CHK,
        S_SCAN1,
        S_SCAN2,
        S_DONE
    } t_state;

    localparam logic PH_A = 1'b0;
    localparam logic PH_B = 1'b1;

    t_state  r_state, n_state;
    t_slot   r_slot, n_slot;
    t_slot   r_next_free, n_next_free;
    t_cnt    r_in_use, n_in_use;
    t_slot   r_p, n_p;
    t_waddr  r_iss_w, n_iss_w;
    logic    r_iss_ph, n_iss_ph;
    logic    r_iss_act, n_iss_act;
    t_waddr  r_ev_w, n_ev_w;
    logic    r_ev_ph, n_ev_ph;
    logic    r_ev_vld, n_ev_vld;
    t_slot   r_granted, n_granted;
    t_result r_res, n_res;

    t_slot            sz_m1;
    t_waddr           last_w;
    t_waddr           p_w;
    logic [BIT_W-1:0] p_b;
    t_word            below_p;
    t_word            m_size;
    t_word            m_lo;
    t_word            free_bits;
    logic             hit;
    logic [BIT_W-1:0] hit_bit;
    t_slot            hit_slot;
    logic             final_word;
    t_cnt             pk1;
    logic             free_bit;
    t_waddr           alloc_start_w;
    t_slot            alloc_start;

    always_comb begin
        sz_m1      = SLOT_W'(i_size - t_cnt'(1));
        last_w     = sz_m1[SLOT_W-1:BIT_W];
        p_w        = r_p[SLOT_W-1:BIT_W];
        p_b        = r_p[BIT_W-1:0];
        below_p    = (t_word'(1) << p_b) - t_word'(1);
        m_size     = (r_ev_w == last_w) ?
                     ((t_word'(2) << sz_m1[BIT_W-1:0]) - t_word'(1)) : '1;
        if (r_ev_ph == PH_A) begin
            m_lo = (r_ev_w == p_w) ? ~below_p : '1;
        end else begin
            m_lo = (r_ev_w == p_w) ? below_p : '1;
        end
        free_bits  = ~i_rd_data & m_size & m_lo;
        hit        = |free_bits;
        hit_bit    = lowest_set(free_bits);
        hit_slot   = {r_ev_w, hit_bit};
        final_word = (r_ev_ph == PH_B) && (r_ev_w == p_w);
        pk1        = {1'b0, hit_slot} + t_cnt'(1);
        free_bit   = i_rd_data[r_slot[BIT_W-1:0]];
        alloc_start   = ({1'b0, r_next_free} < i_size) ? r_next_free : '0;
        alloc_start_w = alloc_start[SLOT_W-1:BIT_W];
    end

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_next_free = r_next_free;
        n_in_use    = r_in_use;
        n_p         = r_p;
        n_iss_w     = r_iss_w;
        n_iss_ph    = r_iss_ph;
        n_iss_act   = r_iss_act;
        n_ev_w      = r_iss_w;
        n_ev_ph     = r_iss_ph;
        n_ev_vld    = 1'b0;
        n_granted   = r_granted;
        n_res       = r_res;
        o_mem       = '0;

        if ((r_state == S_SCAN1) || (r_state == S_SCAN2)) begin
            o_mem.rd_en   = r_iss_act;
            o_mem.rd_addr = r_iss_w;
            n_ev_vld      = r_iss_act;
            if (r_iss_act) begin
                if (r_iss_ph == PH_A) begin
                    if (r_iss_w == last_w) begin
                        n_iss_ph = PH_B;
                        n_iss_w  = '0;
                    end else begin
                        n_iss_w = r_iss_w + t_waddr'(1);
                    end
                end else begin
                    if (r_iss_w == p_w) begin
                        n_iss_act = 1'b0;
                    end else begin
                        n_iss_w = r_iss_w + t_waddr'(1);
                    end
                end
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_slot = i_req.slot;
                    if (i_req.mode == MODE_ALLOC) begin
                        if (r_in_use >= i_size) begin
                            n_res   = '{ST_FULL, '0, r_in_use};
                            n_state = S_DONE;
                        end else begin
                            n_p       = alloc_start;
                            n_iss_w   = alloc_start_w;
                            n_iss_ph  = PH_A;
                            n_iss_act = 1'b1;
                            n_state   = S_SCAN1;
                        end
                    end else begin
                        if ({1'b0, i_req.slot} >= i_size) begin
                            n_res   = '{ST_BAD_FREE, '0, r_in_use};
                            n_state = S_DONE;
                        end else begin
                            n_state = S_FREE_RD;
                        end
                    end
                end
            end
            S_FREE_RD: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = r_slot[SLOT_W-1:BIT_W];
                n_state       = S_FREE_CHK;
            end
            S_FREE_CHK: begin
                if (!free_bit) begin
                    n_res = '{ST_BAD_FREE, '0, r_in_use};
                end else begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_slot[SLOT_W-1:BIT_W];
                    o_mem.wr_data = i_rd_data & ~(t_word'(1) << r_slot[BIT_W-1:0]);
                    if (r_in_use >= i_size) begin
                        n_next_free = r_slot;
                    end
                    if (r_in_use != '0) begin
                        n_in_use = r_in_use - t_cnt'(1);
                        n_res    = '{ST_OK, '0, r_in_use - t_cnt'(1)};
                    end else begin
                        n_res = '{ST_OK, '0, r_in_use};
                    end
                end
                n_state = S_DONE;
            end
            S_SCAN1: begin
                if (r_ev_vld) begin
                    if (hit) begin
                        o_mem.wr_en   = 1'b1;
                        o_mem.wr_addr = r_ev_w;
                        o_mem.wr_data = i_rd_data | (t_word'(1) << hit_bit);
                        n_granted     = hit_slot;
                        n_in_use      = r_in_use + t_cnt'(1);
                        if ((r_in_use + t_cnt'(1)) < i_size) begin
                            n_p       = (pk1 >= i_size) ? '0 : pk1[SLOT_W-1:0];
                            n_iss_w   = n_p[SLOT_W-1:BIT_W];
                            n_iss_ph  = PH_A;
                            n_iss_act = 1'b1;
                            n_ev_vld  = 1'b0;
                            n_state   = S_SCAN2;
                        end else begin
                            n_next_free = '0;
                            n_iss_act   = 1'b0;
                            n_res       = '{ST_OK, hit_slot, r_in_use + t_cnt'(1)};
                            n_state     = S_DONE;
                        end
                    end else if (final_word) begin
                        n_iss_act = 1'b0;
                        n_res     = '{ST_FULL, '0, r_in_use};
                        n_state   = S_DONE;
                    end
                end
            end
            S_SCAN2: begin
                if (r_ev_vld && (hit || final_word)) begin
                    n_next_free = hit ? hit_slot : '0;
                    n_iss_act   = 1'b0;
                    n_res       = '{ST_OK, r_granted, r_in_use};
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_free <= '0;
            r_in_use    <= '0;
            r_iss_act   <= 1'b0;
            r_ev_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            r_in_use    <= n_in_use;
            r_iss_act   <= n_iss_act;
            r_ev_vld    <= n_ev_vld;
        end
        r_slot    <= n_slot;
        r_p       <= n_p;
        r_iss_w   <= n_iss_w;
        r_iss_ph  <= n_iss_ph;
        r_ev_w    <= n_ev_w;
        r_ev_ph   <= n_ev_ph;
        r_granted <= n_granted;
        r_res     <= n_res;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

@@ src/next_fit_slot_allocator_core.sv @@
// Flow: a free reads its bitmap word, then checks and clears the bit; a pool-full or
// out-of-range reject skips the bitmap; an allocate makes two word scans at most.
// Throughput: one request at a time; the word scan over the bitmap memory
// (one 32-bit word read per cycle) sets the allocate time.
// Reset: synchronous, active low; row valid bits all clear together, so the
// whole pool reads free at once with no clearing pass.
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// next_fit_slot_allocator_core
// Next-fit slot allocator: config register, sequencer, bitmap, result stage.
// ----------------------------------------------------------------------------
module next_fit_slot_allocator_core import nfsa_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    nfsa_cfg_if.sink     i_cfg,
    nfsa_req_if.sink     i_req,
    nfsa_rsp_if.source   o_rsp
);

    t_cnt     r_pool_size;
    t_cnt     eff_size;
    t_mem_req mem_req;
    t_word    rd_data;
    logic     res_valid;
    logic     res_ready;
    t_result  res;
    logic     r_out_vld;
    t_result  r_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= t_cnt'(SLOTS);
        end else if (i_cfg.valid) begin
            r_pool_size <= i_cfg.pool_size;
        end
    end

    always_comb begin
        if (r_pool_size == '0) begin
            eff_size = t_cnt'(1);
        end else if (r_pool_size > t_cnt'(SLOTS)) begin
            eff_size = t_cnt'(SLOTS);
        end else begin
            eff_size = r_pool_size;
        end
    end

    nfsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_size      (eff_size),
        .i_req       (i_req),
        .o_mem       (mem_req),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    nfsa_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mem     (mem_req),
        .o_rd_data (rd_data)
    );

    assign res_ready = !r_out_vld || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.granted_slot = r_out.granted_slot;
    assign o_rsp.used_count   = r_out.used_count;

    `NFSA_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, o_rsp.valid, o_rsp.used_count <= t_cnt'(SLOTS))
    `NFSA_ASSERT_SAME(a_grant_zero, i_clk, i_rst_n, o_rsp.valid && (o_rsp.status != ST_OK), o_rsp.granted_slot == '0)
    `NFSA_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
    `NFSA_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_rsp.valid && !o_rsp.ready, o_rsp.valid && $stable(r_out))

endmodule

@@ dv/nfsa_pool_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nfsa_pool_checker
// Watches the config, request and response channels of the slot allocator.
// Keeps its own copy of the used bits, next-free pointer, count and pool size.
// Predicts one response word per accepted request and checks responses in order.
// ----------------------------------------------------------------------------
module nfsa_pool_checker import nfsa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    nfsa_cfg_if  i_cfg,
    nfsa_req_if  i_req,
    nfsa_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    bit          slot_used [SLOTS];
    int unsigned next_free;
    int unsigned in_use;
    t_cnt        pool_size;
    int          mismatches = 0;

    t_result     awaited_replies [$];

    assign o_fail_count = mismatches;

    function automatic int unsigned pool_limit();
        if (pool_size < 1) begin
            return 1;
        end
        if (pool_size > SLOTS) begin
            return SLOTS;
        end
        return pool_size;
    endfunction

    function automatic int unsigned first_free(input int unsigned start,
                                               input int unsigned size);
        int unsigned pos;
        pos = (start < size) ? start : 0;
        for (int unsigned i = 0; i < size; i++) begin
            if (!slot_used[pos]) begin
                return pos;
            end
            pos++;
            if (pos >= size) begin
                pos = 0;
            end
        end
        return size;
    endfunction

    function automatic t_result serve_request(input logic mode, input t_slot slot);
        t_result     res;
        int unsigned size;
        int unsigned pick;
        int unsigned nx;
        size             = pool_limit();
        res.status       = ST_OK;
        res.granted_slot = '0;
        if (mode == MODE_ALLOC) begin
            pick = size;
            if (in_use < size) begin
                pick = first_free(next_free, size);
            end
            if (pick >= size) begin
                res.status = ST_FULL;
            end else begin
                res.granted_slot = t_slot'(pick);
                slot_used[pick]  = 1'b1;
                if (in_use + 1 < size) begin
                    nx        = first_free(pick + 1, size);
                    next_free = (nx < size) ? nx : 0;
                end else begin
                    next_free = 0;
                end
                in_use++;
            end
        end else begin
            if (slot >= size || !slot_used[slot]) begin
                res.status = ST_BAD_FREE;
            end else begin
                slot_used[slot] = 1'b0;
                if (in_use >= size) begin
                    next_free = slot;
                end
                if (in_use > 0) begin
                    in_use--;
                end
            end
        end
        res.used_count = t_cnt'(in_use);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            slot_used = '{default: 1'b0};
            next_free = 0;
            in_use    = 0;
            pool_size = t_cnt'(SLOTS);
            awaited_replies.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                pool_size = i_cfg.pool_size;
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_replies.size() == 0) begin
                    $error("response word with none awaited: status %0d slot %0d count %0d",
                           i_rsp.status, i_rsp.granted_slot, i_rsp.used_count);
                    mismatches++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (i_rsp.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, i_rsp.status);
                        mismatches++;
                    end
                    if (i_rsp.granted_slot !== want.granted_slot) begin
                        $error("granted_slot expected %0d got %0d",
                               want.granted_slot, i_rsp.granted_slot);
                        mismatches++;
                    end
                    if (i_rsp.used_count !== want.used_count) begin
                        $error("used_count expected %0d got %0d",
                               want.used_count, i_rsp.used_count);
                        mismatches++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                awaited_replies.push_back(serve_request(i_req.mode, i_req.slot));
            end
            o_pending <= awaited_replies.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the next-fit slot allocator: directed allocate and free words
// across pool sizes, then random phases with random pacing on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import nfsa_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1750;
    localparam int SETTLE       = 80;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int fail_count;
    int pending;
    int cycles    = 0;
    int max_gap   = 6;
    int max_stall = 6;
    int pool_eff  = SLOTS;
    int sent      = 0;

    nfsa_cfg_if u_cfg_if ();
    nfsa_req_if u_req_if ();
    nfsa_rsp_if u_rsp_if ();

    next_fit_slot_allocator_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (u_cfg_if),
        .i_req   (u_req_if),
        .o_rsp   (u_rsp_if)
    );

    nfsa_pool_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (u_cfg_if),
        .i_req        (u_req_if),
        .i_rsp        (u_rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : rsp_side
        int stall;
        u_rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, max_stall);
            if (stall > 0) begin
                u_rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            u_rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(u_rsp_if.valid && u_rsp_if.ready));
        end
    end

    task automatic push_request(input logic mode, input t_slot slot);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            u_req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        u_req_if.valid <= 1'b1;
        u_req_if.mode  <= mode;
        u_req_if.slot  <= slot;
        do @(posedge i_clk); while (!u_req_if.ready);
        sent++;
    endtask

    task automatic wait_idle();
        u_req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_pool_size(input t_cnt value);
        u_cfg_if.valid     <= 1'b1;
        u_cfg_if.pool_size <= value;
        do @(posedge i_clk); while (!u_cfg_if.ready);
        u_cfg_if.valid <= 1'b0;
        pool_eff = (value < 1) ? 1 : (value > SLOTS) ? SLOTS : int'(value);
    endtask

    function automatic t_slot pick_slot();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            return t_slot'($urandom_range(0, pool_eff - 1));
        end
        if (roll < 85) begin
            return t_slot'(SLOTS - 1);
        end
        return t_slot'($urandom_range(0, SLOTS - 1));
    endfunction

    function automatic t_cnt draw_pool_size();
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return t_cnt'(1);
            end
            2: begin
                return '1;
            end
            3: begin
                return t_cnt'(SLOTS);
            end
            4: begin
                return t_cnt'($urandom_range(SLOTS + 1, 2047));
            end
            5, 6, 7: begin
                return t_cnt'($urandom_range(2, 16));
            end
            default: begin
                return t_cnt'($urandom_range(17, 200));
            end
        endcase
    endfunction

    task automatic run_phase(input t_cnt size_value, input int items, input int alloc_pct);
        wait_idle();
        write_pool_size(size_value);
        case ($urandom_range(0, 3))
            0: begin
                max_gap   = 0;
                max_stall = 0;
            end
            1: begin
                max_gap   = 6;
                max_stall = 0;
            end
            2: begin
                max_gap   = 0;
                max_stall = 6;
            end
            default: begin
                max_gap   = 6;
                max_stall = 6;
            end
        endcase
        repeat (items) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
                push_request(MODE_ALLOC, t_slot'($urandom));
            end else begin
                push_request(MODE_FREE, pick_slot());
            end
            if ($urandom_range(0, 199) == 0) begin
                wait_idle();
            end
        end
    endtask

    initial begin
        int directed;
        u_cfg_if.valid     <= 1'b0;
        u_cfg_if.pool_size <= '0;
        u_req_if.valid     <= 1'b0;
        u_req_if.mode      <= MODE_ALLOC;
        u_req_if.slot      <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full-size pool after reset
        push_request(MODE_ALLOC, '0);
        push_request(MODE_ALLOC, '1);
        push_request(MODE_ALLOC, '0);
        push_request(MODE_FREE, t_slot'(1));
        push_request(MODE_FREE, t_slot'(1));
        push_request(MODE_FREE, t_slot'(SLOTS - 1));
        push_request(MODE_ALLOC, '0);
        push_request(MODE_FREE, '0);

        // zero size saturates to one slot: full, then a free of an unused slot and an out-of-range free
        wait_idle();
        write_pool_size('0);
        push_request(MODE_ALLOC, '0);
        push_request(MODE_FREE, '0);
        push_request(MODE_FREE, t_slot'(2));

        // oversize saturates to the whole pool
        wait_idle();
        write_pool_size('1);
        push_request(MODE_FREE, '1);
        push_request(MODE_ALLOC, '0);

        // shrink below the pointer: stale pointer, then full and refill
        wait_idle();
        write_pool_size(t_cnt'(4));
        push_request(MODE_ALLOC, '0);
        push_request(MODE_ALLOC, '0);
        push_request(MODE_FREE, t_slot'(2));
        push_request(MODE_ALLOC, '0);
        push_request(MODE_ALLOC, '0);
        directed = sent;

        // fill the whole pool and wrap the pointer
        run_phase(t_cnt'(SLOTS), 1040, 97);
        while (sent < directed + RANDOM_ITEMS) begin
            run_phase(draw_pool_size(), $urandom_range(30, 100), $urandom_range(30, 80));
        end

        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
